// ----- sv/crrf_pkg.sv -----
package crrf_pkg;

  localparam int CHROM_W         = 8;
  localparam int POS_W           = 32;
  localparam int COVER_W         = 24;
  localparam int LEN_OUT_W       = 32;
  localparam int THR_W           = 16;
  localparam int REGION_FLOOR_W  = 32;

  localparam int POS_BITS        = 32;
  localparam int CHROM_BITS      = 8;
  localparam int COVER_FRAC_BITS = 8;
  localparam int THR_FRAC_BITS   = 8;
  localparam int THR_ONE         = 1 << THR_FRAC_BITS;

  localparam int PROD_A          = THR_W + COVER_W;
  localparam int PROD_B          = THR_W + COVER_FRAC_BITS;
  localparam int PROD_C          = COVER_W + THR_FRAC_BITS;
  localparam int PROD_AB         = (PROD_A > PROD_B) ? PROD_A : PROD_B;
  localparam int PROD_W          = (PROD_AB > PROD_C) ? PROD_AB : PROD_C;

  localparam int QDEPTH          = 4;
  localparam int QAW             = $clog2(QDEPTH);

  localparam int CFG_AW          = 4;
  localparam int CFG_DW          = 32;

  localparam logic [1:0] REG_COVER_FLOOR  = 2'd0;
  localparam logic [1:0] REG_REGION_FLOOR = 2'd1;
  localparam logic [1:0] REG_RATIO_THR    = 2'd2;

  typedef logic [CHROM_BITS-1:0]     chrom_t;
  typedef logic [POS_BITS-1:0]       pos_t;
  typedef logic [COVER_W-1:0]        cover_t;
  typedef logic [THR_W-1:0]          thr_t;
  typedef logic [PROD_W-1:0]         prod_t;
  typedef logic [REGION_FLOOR_W-1:0] region_floor_t;

  typedef struct packed {
    chrom_t chrom;
    pos_t   pos;
    logic   valid;
    logic   last;
  } item_t;

  typedef struct packed {
    cover_t        cover_floor;
    region_floor_t region_floor;
    thr_t          ratio_threshold;
  } cfg_t;

endpackage

// ----- sv/crrf_in_if.sv -----
interface crrf_in_if import crrf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHROM_W-1:0]   chrom_id;
  logic [POS_W-1:0]     base_pos;
  logic [COVER_W-1:0]   sample_cover;
  logic [COVER_W-1:0]   control_cover;
  logic                 stream_end;

  modport source(output valid, chrom_id, base_pos, sample_cover, control_cover, stream_end,
                 input ready);
  modport sink(input valid, chrom_id, base_pos, sample_cover, control_cover, stream_end,
               output ready);
endinterface

// ----- sv/crrf_out_if.sv -----
interface crrf_out_if import crrf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHROM_W-1:0]   region_chrom;
  logic [POS_W-1:0]     region_first;
  logic [POS_W-1:0]     region_last;
  logic [LEN_OUT_W-1:0] region_length;

  modport source(output valid, region_chrom, region_first, region_last, region_length,
                 input ready);
  modport sink(input valid, region_chrom, region_first, region_last, region_length,
               output ready);
endinterface

// ----- sv/crrf_front.sv -----
module crrf_front import crrf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  crrf_in_if.sink      in_ch,
  input  logic         q_full,
  output logic         q_push,
  output item_t        q_data
);

  logic   s1_v_r, s1_v_nxt;
  chrom_t s1_chrom_r;
  pos_t   s1_pos_r;
  logic   s1_last_r;
  cover_t s1_s_r, s1_c_r;
  prod_t  s1_prod_s_r, s1_prod_c_r;
  logic   take;
  logic   enough, ratio;

  function automatic logic ratio_ok(input cover_t num, input cover_t den, input prod_t prod_den,
                                    input thr_t thr, input cover_t mc);
    prod_t scaled;
    prod_t thr_scaled;
    logic  res;
    scaled     = prod_t'(num) << THR_FRAC_BITS;
    thr_scaled = prod_t'(thr) << COVER_FRAC_BITS;
    if (den == '0 || num == den) begin
      if (mc <= num) res = (thr_scaled <= scaled);
      else res = (prod_t'(thr) <= prod_t'(THR_ONE));
    end else begin
      res = (prod_den <= scaled);
    end
    return res;
  endfunction

  assign in_ch.ready = !s1_v_r || !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign q_push      = s1_v_r && !q_full;

  always_comb begin
    if (take) s1_v_nxt = 1'b1;
    else if (q_push) s1_v_nxt = 1'b0;
    else s1_v_nxt = s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_chrom_r  <= chrom_t'(in_ch.chrom_id);
      s1_pos_r    <= pos_t'(in_ch.base_pos);
      s1_last_r   <= in_ch.stream_end;
      s1_s_r      <= in_ch.sample_cover;
      s1_c_r      <= in_ch.control_cover;
      s1_prod_s_r <= prod_t'(cfg.ratio_threshold) * prod_t'(in_ch.sample_cover);
      s1_prod_c_r <= prod_t'(cfg.ratio_threshold) * prod_t'(in_ch.control_cover);
    end
  end

  always_comb begin
    enough = (cfg.cover_floor <= s1_s_r) || (cfg.cover_floor <= s1_c_r);
    ratio  = ratio_ok(s1_s_r, s1_c_r, s1_prod_c_r, cfg.ratio_threshold, cfg.cover_floor) ||
             ratio_ok(s1_c_r, s1_s_r, s1_prod_s_r, cfg.ratio_threshold, cfg.cover_floor);
    q_data.chrom = s1_chrom_r;
    q_data.pos   = s1_pos_r;
    q_data.valid = enough && ratio;
    q_data.last  = s1_last_r;
  end

endmodule

// ----- sv/crrf_queue.sv -----
module crrf_queue import crrf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_data,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;

  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop) rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ----- sv/crrf_back.sv -----
module crrf_back import crrf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  region_floor_t region_floor,
  input  item_t         head,
  input  logic          q_empty,
  output logic          q_pop,
  crrf_out_if.source    out_ch
);

  localparam int LEN_W = (POS_BITS + 1 > LEN_OUT_W + 1) ? POS_BITS + 1 : LEN_OUT_W + 1;

  logic   open_r, open_nxt;
  chrom_t run_chrom_r;
  pos_t   run_first_r, run_last_r;
  logic   out_v_r, out_v_nxt;
  chrom_t out_chrom_r;
  pos_t   out_first_r, out_last_r;
  logic [LEN_OUT_W-1:0] out_len_r;

  logic       cont, emit, len_ok;
  pos_t       cand_last, diff;
  logic [LEN_W-1:0] len;
  logic [LEN_OUT_W-1:0] len_sat;

  assign q_pop = !q_empty && (!out_v_r || out_ch.ready);

  always_comb begin
    cont = open_r && head.valid && head.chrom == run_chrom_r &&
           ({1'b0, head.pos} <= {1'b0, run_last_r} + (POS_BITS+1)'(1));
    cand_last = cont ? head.pos : run_last_r;
    diff    = (cand_last >= run_first_r) ? cand_last - run_first_r : run_first_r - cand_last;
    len     = LEN_W'(diff) + LEN_W'(1);
    len_ok  = (len > LEN_W'(1)) && (LEN_W'(region_floor) <= len);
    len_sat = (len > LEN_W'({LEN_OUT_W{1'b1}})) ? {LEN_OUT_W{1'b1}} : LEN_OUT_W'(len);
    emit    = cont ? (head.last && len_ok) : (open_r && len_ok);

    if (cont) open_nxt = !head.last;
    else open_nxt = head.valid && !head.last;
    if (!q_pop) open_nxt = open_r;

    if (q_pop) out_v_nxt = emit;
    else out_v_nxt = out_v_r && !out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      open_r  <= open_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (cont) begin
        run_last_r <= head.pos;
      end else if (head.valid) begin
        run_chrom_r <= head.chrom;
        run_first_r <= head.pos;
        run_last_r  <= head.pos;
      end
      if (emit) begin
        out_chrom_r <= run_chrom_r;
        out_first_r <= run_first_r;
        out_last_r  <= cand_last;
        out_len_r   <= len_sat;
      end
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.region_chrom  = CHROM_W'(out_chrom_r);
  assign out_ch.region_first  = POS_W'(out_first_r);
  assign out_ch.region_last   = POS_W'(out_last_r);
  assign out_ch.region_length = out_len_r;

endmodule

// ----- sv/coverage_ratio_region_finder.sv -----
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    chrom_id, base_pos, sample_cover, control_cover, stream_end
// out_ch    out  valid/ready    region_chrom, region_first, region_last, region_length
// apb       in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// One position per cycle sustained while out_ch accepts; an input passes front register, queue, output register:
// ratio products at the transfer, validity compare into a 4-entry queue, then run update.
// The run tracker pops one item per cycle while the output register is free.
// Synchronous active-low reset empties the pipeline and queue, closes any run,
// and restores the register defaults. Stalls on either side are absorbed by
// the queue; in_ch.ready drops only once the queue and front stage are full.
module coverage_ratio_region_finder import crrf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  crrf_in_if.sink           in_ch,
  crrf_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg_r, cfg_nxt;
  logic  wr_en;
  logic  q_push, q_pop, q_full, q_empty;
  item_t q_in, q_head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_COVER_FLOOR:  cfg_nxt.cover_floor     = COVER_W'(pwdata);
        REG_REGION_FLOOR: cfg_nxt.region_floor    = REGION_FLOOR_W'(pwdata);
        REG_RATIO_THR:    cfg_nxt.ratio_threshold = THR_W'(pwdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cover_floor     <= '0;
      cfg_r.region_floor    <= REGION_FLOOR_W'(2);
      cfg_r.ratio_threshold <= THR_W'(512);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COVER_FLOOR:  prdata = CFG_DW'(cfg_r.cover_floor);
      REG_REGION_FLOOR: prdata = CFG_DW'(cfg_r.region_floor);
      REG_RATIO_THR:    prdata = CFG_DW'(cfg_r.ratio_threshold);
      default:          prdata = '0;
    endcase
  end

  crrf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  crrf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  crrf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .region_floor (cfg_r.region_floor),
    .head         (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_ch       (out_ch)
  );

  a_short_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.region_length > LEN_OUT_W'(1))
    else $error("region shorter than two positions");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_full)
    else $error("input stalled while queue has room");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_empty)
    else $error("queue full and empty together");

  a_pop_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_ch.valid || out_ch.ready))
    else $error("queue popped while result is stalled");

endmodule
